// File: rtl/core/owl_pkg.sv
// owl_pkg: shared constants, codes and types of the ordered word list engine
// no dependencies; used by every module of the block by scoped names
package owl_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int WORD_W   = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // port field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int STAT_W   = 3;
   localparam int FOUND_W  = 6;
   localparam int COUNT_W  = 7;

   // width that holds both a target position and a count
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SORTED_INS = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   // per-cell control from the sequencer
   typedef struct packed {
      logic cmp_en;     // capture compare flags against the item word
      logic load;       // take the item word
      logic from_left;  // take the word of the cell in front
      logic from_right; // take the word of the cell behind
   } cell_ctrl_type;

endpackage

// File: rtl/core/owl_cell.sv
// owl_cell: one list entry with its compare flags and neighbor shift mux
// depends on owl_pkg
module owl_cell (
   input  logic                          clock,
   input  logic [owl_pkg::WORD_W-1:0]    word,
   input  owl_pkg::cell_ctrl_type        ctrl,
   input  logic [owl_pkg::WORD_W-1:0]    left_word,
   input  logic [owl_pkg::WORD_W-1:0]    right_word,
   output logic [owl_pkg::WORD_W-1:0]    entry,
   output logic                          le_flag,
   output logic                          eq_flag
);

   logic [owl_pkg::WORD_W-1:0] entry_ff, entry_in;
   logic                       le_ff, le_in;
   logic                       eq_ff, eq_in;

   // next entry: load, shift back, shift forward or hold
   always_comb begin
      if (ctrl.load) begin
         entry_in = word;
      end else if (ctrl.from_left) begin
         entry_in = left_word;
      end else if (ctrl.from_right) begin
         entry_in = right_word;
      end else begin
         entry_in = entry_ff;
      end
   end

   // compare flags, captured in the compare cycle
   always_comb begin
      if (ctrl.cmp_en) begin
         le_in = (word <= entry_ff);
         eq_in = (word == entry_ff);
      end else begin
         le_in = le_ff;
         eq_in = eq_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      le_ff    <= le_in;
      eq_ff    <= eq_in;
   end

   assign entry   = entry_ff;
   assign le_flag = le_ff;
   assign eq_flag = eq_ff;

endmodule

// File: rtl/core/owl_first_set.sv
// owl_first_set: finds the lowest set bit of a per-cell flag vector
// depends on owl_pkg
module owl_first_set (
   input  logic [owl_pkg::CAPACITY-1:0] flags,
   output logic                         hit,
   output logic [owl_pkg::IDX_W-1:0]    index
);

   // scan from the back so the lowest set bit wins
   always_comb begin
      index = '0;
      for (int i = owl_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (flags[i]) begin
            index = owl_pkg::IDX_W'(i);
         end
      end
   end

   assign hit = |flags;

endmodule

// File: rtl/core/ordered_word_list_engine.sv
// ordered_word_list_engine: top level, sequencer and row of list cells
// depends on owl_pkg, owl_cell, owl_first_set
//
// Usage
//   req_* carries one command item: command, word_value, target_position.
//   rsp_* returns one result item per command: status, found_position,
//   entry_count and front_word after the command.
//   Both channels move an item on a clock edge with valid high, stall low.
// Sequencing
//   An item passes a compare state, in which every cell registers its
//   less-or-equal and equal flags against the item word, and then an update
//   state, in which the first-hit search picks the position, all cells shift
//   or load at once and the result is loaded into the output register. The
//   next item is taken in the update cycle, so a new item is accepted
//   before the last one is through.
// Reset
//   Synchronous, active high: the list is empty and no result is pending.
// Receiver stall
//   A result waits in the output register. The next item is still taken
//   and compared; its update waits until the waiting result is taken, and
//   no further item is accepted meanwhile.
module ordered_word_list_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [owl_pkg::CMD_W-1:0]      req_command,
   input  logic [owl_pkg::WORD_W-1:0]     req_word_value,
   input  logic [owl_pkg::POS_W-1:0]      req_target_position,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [owl_pkg::STAT_W-1:0]     rsp_status,
   output logic [owl_pkg::FOUND_W-1:0]    rsp_found_position,
   output logic [owl_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic [owl_pkg::WORD_W-1:0]     rsp_front_word
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [owl_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [owl_pkg::WORD_W-1:0]      word_ff, word_in;
   logic [owl_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [owl_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [owl_pkg::STAT_W-1:0]      status_ff, status_in;
   logic [owl_pkg::IDX_W-1:0]       found_ff, found_in;

   logic                            req_take;
   logic                            apply_fire;
   logic                            rsp_take;

   logic [owl_pkg::WORD_W-1:0]      entry_w [owl_pkg::CAPACITY];
   owl_pkg::cell_ctrl_type          ctrl_w  [owl_pkg::CAPACITY];
   logic [owl_pkg::CAPACITY-1:0]    le_w, eq_w, live_w;

   logic                            le_hit, eq_hit;
   logic [owl_pkg::IDX_W-1:0]       le_idx, eq_idx;

   logic                            is_full, is_empty, is_range;
   logic                            ins_go, del_go;
   logic [owl_pkg::CNT_W-1:0]       ins_idx, del_idx;

   // handshake
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = !((state_ff == S_IDLE) || apply_fire);
   assign req_take   = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_fire) begin
               state_in = req_take ? S_CMP : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // item capture
   assign cmd_in  = req_take ? req_command         : cmd_ff;
   assign word_in = req_take ? req_word_value      : word_ff;
   assign pos_in  = req_take ? req_target_position : pos_ff;

   // list status seen by the update
   assign is_full  = (count_ff == owl_pkg::CNT_W'(owl_pkg::CAPACITY));
   assign is_empty = (count_ff == '0);
   assign is_range = (owl_pkg::CMP_W'(pos_ff) >= owl_pkg::CMP_W'(count_ff));

   // first stored entry not below the word, and first equal entry
   owl_first_set u_first_le (
      .flags (le_w & live_w),
      .hit   (le_hit),
      .index (le_idx)
   );

   owl_first_set u_first_eq (
      .flags (eq_w & live_w),
      .hit   (eq_hit),
      .index (eq_idx)
   );

   // command decode for the update cycle
   always_comb begin
      ins_go    = 1'b0;
      del_go    = 1'b0;
      ins_idx   = '0;
      del_idx   = '0;
      status_in = owl_pkg::ST_OK;
      found_in  = '0;
      unique case (cmd_ff) inside
         owl_pkg::CMD_PUSH_FRONT, owl_pkg::CMD_PUSH_BACK, owl_pkg::CMD_SORTED_INS: begin
            if (is_full) begin
               status_in = owl_pkg::ST_FULL;
            end else begin
               ins_go = 1'b1;
               if (cmd_ff == owl_pkg::CMD_PUSH_FRONT) begin
                  ins_idx = '0;
               end else if (cmd_ff == owl_pkg::CMD_PUSH_BACK) begin
                  ins_idx = count_ff;
               end else begin
                  ins_idx = le_hit ? owl_pkg::CNT_W'(le_idx) : count_ff;
               end
            end
         end
         owl_pkg::CMD_POP_FRONT: begin
            if (is_empty) begin
               status_in = owl_pkg::ST_EMPTY;
            end else begin
               del_go  = 1'b1;
               del_idx = '0;
            end
         end
         owl_pkg::CMD_FIND: begin
            if (eq_hit) begin
               found_in = eq_idx;
            end else begin
               status_in = owl_pkg::ST_NOT_FOUND;
            end
         end
         owl_pkg::CMD_DELETE: begin
            if (is_range) begin
               status_in = owl_pkg::ST_RANGE;
            end else begin
               del_go  = 1'b1;
               del_idx = owl_pkg::CNT_W'(pos_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (apply_fire && ins_go) begin
         count_in = count_ff + owl_pkg::CNT_W'(1);
      end else if (apply_fire && del_go) begin
         count_in = count_ff - owl_pkg::CNT_W'(1);
      end
   end

   // result register
   always_comb begin
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // row of cells
   for (genvar i = 0; i < owl_pkg::CAPACITY; i++) begin : g_cell
      logic [owl_pkg::WORD_W-1:0] left_w, right_w;

      if (i == 0) begin : g_front
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = entry_w[i-1];
      end

      if (i == owl_pkg::CAPACITY - 1) begin : g_back
         assign right_w = entry_w[i];
      end else begin : g_inner_r
         assign right_w = entry_w[i+1];
      end

      assign live_w[i] = (count_ff > owl_pkg::CNT_W'(i));

      assign ctrl_w[i].cmp_en     = (state_ff == S_CMP);
      assign ctrl_w[i].load       = apply_fire && ins_go && (owl_pkg::CNT_W'(i) == ins_idx);
      assign ctrl_w[i].from_left  = apply_fire && ins_go && (owl_pkg::CNT_W'(i) > ins_idx);
      assign ctrl_w[i].from_right = apply_fire && del_go && (owl_pkg::CNT_W'(i) >= del_idx);

      owl_cell u_cell (
         .clock      (clock),
         .word       (word_ff),
         .ctrl       (ctrl_w[i]),
         .left_word  (left_w),
         .right_word (right_w),
         .entry      (entry_w[i]),
         .le_flag    (le_w[i]),
         .eq_flag    (eq_w[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      word_ff <= word_in;
      pos_ff  <= pos_in;
      if (apply_fire) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   // result fields; list state only moves when a new result is loaded
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = owl_pkg::FOUND_W'(found_ff);
   assign rsp_entry_count    = owl_pkg::COUNT_W'(count_ff);
   assign rsp_front_word     = is_empty ? '0 : entry_w[0];

endmodule

// File: rtl/core/owl_checker.sv
// owl_checker: port-level checks of the ordered word list engine, bound to the top level
// depends on owl_pkg and ordered_word_list_engine
module owl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [owl_pkg::STAT_W-1:0]     rsp_status,
   input logic [owl_pkg::COUNT_W-1:0]    rsp_entry_count,
   input logic [owl_pkg::WORD_W-1:0]     rsp_front_word
);

   // an accepted item occupies the compare cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken during compare cycle");

   // an empty list reports a zero front word
   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_entry_count == '0)) |-> (rsp_front_word == '0))
      else $error("nonzero front word on empty list");

   // a full flag only with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == owl_pkg::ST_FULL))
         |-> (rsp_entry_count == owl_pkg::COUNT_W'(owl_pkg::CAPACITY)))
      else $error("full status with spare room");

   // an empty flag only with an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == owl_pkg::ST_EMPTY)) |-> (rsp_entry_count == '0))
      else $error("empty status with stored entries");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_front_word)))
      else $error("stalled result item changed");

endmodule

bind ordered_word_list_engine owl_checker u_owl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_front_word  (rsp_front_word)
);
